FILE: src/bsm_pkg.sv
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and codes for the bounding sphere merge block: the request to
// the iterative arithmetic unit and the merge outcome codes.
// ----------------------------------------------------------------------------
package bsm_pkg;

    // digit width of the shift-add multiplier
    localparam int DIGIT_BITS = 4;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_SQRT = 2'd1,
        OP_DIV  = 2'd2
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_iter_req;

    typedef enum logic [2:0] {
        CASE_IGNORED   = 3'd0,
        CASE_FIRST     = 3'd1,
        CASE_CONTAINED = 3'd2,
        CASE_REPLACED  = 3'd3,
        CASE_GROWN     = 3'd4
    } t_case;

endpackage

FILE: src/bsm_iter.sv
// ----------------------------------------------------------------------------
// bsm_iter
// Iterative arithmetic unit around one shared add/subtract: radix-16
// shift-add multiply, bit-per-step integer square root and restoring divide.
// ----------------------------------------------------------------------------
module bsm_iter
    import bsm_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_iter_req                  i_req,
    input  logic [COORD_WIDTH:0]       i_a,    // multiplicand or divisor
    input  logic [COORD_WIDTH:0]       i_b,    // multiplier
    input  logic [2*COORD_WIDTH+1:0]   i_n,    // radicand or dividend
    output logic                       o_done,
    output logic [2*COORD_WIDTH+1:0]   o_acc,  // product
    output logic [COORD_WIDTH:0]       o_q     // root or quotient
);

    localparam int OW    = COORD_WIDTH + 1;
    localparam int W     = 2 * COORD_WIDTH + 2;
    localparam int ND    = (OW + DIGIT_BITS - 1) / DIGIT_BITS;
    localparam int BW    = ND * DIGIT_BITS;
    localparam int CNT_W = $clog2(OW + 1);

    logic             r_busy;
    logic             r_done;
    t_op              r_op;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_acc;
    logic [W-1:0]     r_sh;
    logic [OW-1:0]    r_a;
    logic [OW-1:0]    r_q;

    logic [DIGIT_BITS-1:0]    w_digit;
    logic [OW+DIGIT_BITS-1:0] w_pp;
    logic [OW+2:0]            w_rem_root;
    logic [OW:0]              w_rem_div;
    logic [W-1:0]             w_x;
    logic [W-1:0]             w_y;
    logic                     w_sub;
    logic [W:0]               w_sum;
    logic                     w_ge;

    always_comb begin
        w_digit    = r_sh[W-1 -: DIGIT_BITS];
        w_pp       = r_a * w_digit;
        w_rem_root = {r_acc[OW:0], r_sh[W-1 -: 2]};
        w_rem_div  = {r_acc[OW-1:0], r_sh[W-1]};
        case (r_op)
            OP_MUL: begin
                w_x   = r_acc << DIGIT_BITS;
                w_y   = W'(w_pp);
                w_sub = 1'b0;
            end
            OP_SQRT: begin
                w_x   = W'(w_rem_root);
                w_y   = W'({r_q, 2'b01});
                w_sub = 1'b1;
            end
            OP_DIV: begin
                w_x   = W'(w_rem_div);
                w_y   = W'(r_a);
                w_sub = 1'b1;
            end
            default: begin
                w_x   = '0;
                w_y   = '0;
                w_sub = 1'b0;
            end
        endcase
        // carry out of x + ~y + 1 is set when x >= y
        w_sum = {1'b0, w_x} + {1'b0, (w_sub ? ~w_y : w_y)} + (W+1)'(w_sub);
        w_ge  = w_sum[W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op <= i_req.op;
            case (i_req.op)
                OP_MUL: begin
                    r_cnt <= CNT_W'(ND);
                    r_acc <= '0;
                    r_a   <= i_a;
                    r_sh  <= {BW'(i_b), {(W-BW){1'b0}}};
                end
                OP_SQRT: begin
                    r_cnt <= CNT_W'(OW);
                    r_acc <= '0;
                    r_q   <= '0;
                    r_sh  <= i_n;
                end
                OP_DIV: begin
                    // top half is already below the divisor
                    r_cnt <= CNT_W'(OW);
                    r_acc <= W'(i_n[W-1 -: OW]);
                    r_sh  <= i_n << OW;
                    r_a   <= i_a;
                    r_q   <= '0;
                end
                default: begin
                    r_cnt <= '0;
                end
            endcase
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            case (r_op)
                OP_MUL: begin
                    r_acc <= w_sum[W-1:0];
                    r_sh  <= r_sh << DIGIT_BITS;
                end
                OP_SQRT: begin
                    r_acc <= w_ge ? w_sum[W-1:0] : w_x;
                    r_q   <= {r_q[OW-2:0], w_ge};
                    r_sh  <= r_sh << 2;
                end
                OP_DIV: begin
                    r_acc <= w_ge ? w_sum[W-1:0] : w_x;
                    r_q   <= {r_q[OW-2:0], w_ge};
                    r_sh  <= r_sh << 1;
                end
                default: begin
                    r_acc <= r_acc;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
    assign o_q    = r_q;

endmodule

FILE: src/bounding_sphere_merge.sv
// ----------------------------------------------------------------------------
// bounding_sphere_merge
// Ignored or first-copy beats go straight to the output stage; contained or
//   replaced beats pass square, root and classify; grown beats also scale and
//   divide each axis.
// Throughput: one beat at a time, paced by the shared multiply/root/divide unit.
// Reset: synchronous active low, aggregate cleared to invalid with zero fields.
// ----------------------------------------------------------------------------
module bounding_sphere_merge
    import bsm_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // in_center_x, in_center_y, in_center_z, in_radius, zero pad
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]    s_axis_tdata,
    // restart, sphere_valid
    input  logic [1:0]                            s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // out_center_x, out_center_y, out_center_z, out_radius, zero pad
    output logic [((4*COORD_WIDTH+7)/8)*8-1:0]    m_axis_tdata,
    // out_valid, merge_case[2:0], radius_saturated
    output logic [4:0]                            m_axis_tuser
);

    localparam int CW  = COORD_WIDTH;
    localparam int OW  = CW + 1;
    localparam int W   = 2 * CW + 2;
    localparam int TDW = ((4 * CW + 7) / 8) * 8;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SQUARE = 8'b0000_0010,
        ST_ROOT   = 8'b0000_0100,
        ST_CLASS  = 8'b0000_1000,
        ST_GROW   = 8'b0001_0000,
        ST_SCALE  = 8'b0010_0000,
        ST_DIVIDE = 8'b0100_0000,
        ST_FIN    = 8'b1000_0000
    } t_state;

    t_state          r_state;
    t_state          n_state;
    logic            r_wait;
    logic [1:0]      r_ax;
    logic            r_agg_valid;
    logic [CW-1:0]   r_agg_c [3];
    logic [CW-1:0]   r_agg_r;
    logic [CW-1:0]   r_in_c [3];
    logic [CW-1:0]   r_in_r;
    logic            r_neg [3];
    logic [OW-1:0]   r_mag [3];
    logic [W-1:0]    r_sq;
    logic [OW-1:0]   r_d;
    logic [OW-1:0]   r_r;
    logic [OW-1:0]   r_k;
    t_case           r_case;
    logic            r_sat;
    logic            r_m_valid;
    logic [TDW-1:0]  r_m_data;
    logic [4:0]      r_m_user;

    logic            w_accept;
    logic            w_restart;
    logic            w_sv;
    logic            w_copy;
    logic [CW-1:0]   w_in_c [3];
    logic [CW-1:0]   w_in_r;
    logic [OW-1:0]   w_off [3];
    logic [OW-1:0]   w_mag [3];
    logic [OW:0]     w_d_rs;
    logic [OW:0]     w_d_ra;
    logic [OW:0]     w_total;
    logic            w_contained;
    logic            w_replace;
    logic [OW:0]     w_cext;
    logic [OW:0]     w_newc;
    logic            w_out_free;

    t_iter_req       w_req;
    logic [OW-1:0]   w_a;
    logic [OW-1:0]   w_b;
    logic [W-1:0]    w_n;
    logic            w_done;
    logic [W-1:0]    w_acc;
    logic [OW-1:0]   w_q;

    bsm_iter #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_n     (w_n),
        .o_done  (w_done),
        .o_acc   (w_acc),
        .o_q     (w_q)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_restart     = s_axis_tuser[0];
    assign w_sv          = s_axis_tuser[1];
    assign w_copy        = w_sv && (w_restart || !r_agg_valid);
    assign w_in_r        = s_axis_tdata[3*CW +: CW];
    assign w_out_free    = !r_m_valid || m_axis_tready;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_in_c[i] = s_axis_tdata[i*CW +: CW];
            w_off[i]  = {w_in_c[i][CW-1], w_in_c[i]} - {r_agg_c[i][CW-1], r_agg_c[i]};
            w_mag[i]  = w_off[i][OW-1] ? (~w_off[i] + 1'b1) : w_off[i];
        end
    end

    always_comb begin
        w_d_rs      = {1'b0, r_d} + (OW+1)'(r_in_r);
        w_d_ra      = {1'b0, r_d} + (OW+1)'(r_agg_r);
        w_contained = (w_d_rs <= (OW+1)'(r_agg_r));
        w_replace   = (w_d_ra <= (OW+1)'(r_in_r));
        w_total     = (OW+1)'(r_d) + (OW+1)'(r_agg_r) + (OW+1)'(r_in_r);
        // center moves toward the input by the unsigned shift
        w_cext      = {{2{r_agg_c[r_ax][CW-1]}}, r_agg_c[r_ax]};
        w_newc      = r_neg[r_ax] ? (w_cext - (OW+1)'(w_q)) : (w_cext + (OW+1)'(w_q));
    end

    always_comb begin
        w_req.start = !r_wait && (r_state == ST_SQUARE || r_state == ST_ROOT
                                  || r_state == ST_SCALE || r_state == ST_DIVIDE);
        case (r_state)
            ST_ROOT:   w_req.op = OP_SQRT;
            ST_DIVIDE: w_req.op = OP_DIV;
            default:   w_req.op = OP_MUL;
        endcase
        w_a = (r_state == ST_DIVIDE) ? r_d : r_mag[r_ax];
        w_b = (r_state == ST_SCALE) ? r_k : r_mag[r_ax];
        w_n = (r_state == ST_ROOT) ? r_sq : w_acc;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = (!w_sv || w_copy) ? ST_FIN : ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (w_done && r_ax == 2'd2) begin
                    n_state = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (w_done) begin
                    n_state = ST_CLASS;
                end
            end
            ST_CLASS: begin
                n_state = (w_contained || w_replace) ? ST_FIN : ST_GROW;
            end
            ST_GROW: begin
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (w_done) begin
                    n_state = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (w_done) begin
                    n_state = (r_ax == 2'd2) ? ST_FIN : ST_SCALE;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control and aggregate state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wait      <= 1'b0;
            r_m_valid   <= 1'b0;
            r_agg_valid <= 1'b0;
            r_agg_r     <= '0;
            for (int i = 0; i < 3; i++) begin
                r_agg_c[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_req.start) begin
                r_wait <= 1'b1;
            end else if (w_done) begin
                r_wait <= 1'b0;
            end

            if (r_state == ST_FIN && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end

            if (w_accept) begin
                if (w_copy) begin
                    r_agg_valid <= 1'b1;
                    r_agg_r     <= w_in_r;
                    for (int i = 0; i < 3; i++) begin
                        r_agg_c[i] <= w_in_c[i];
                    end
                end else if (w_restart) begin
                    r_agg_valid <= 1'b0;
                    r_agg_r     <= '0;
                    for (int i = 0; i < 3; i++) begin
                        r_agg_c[i] <= '0;
                    end
                end
            end

            if (r_state == ST_CLASS && !w_contained && w_replace) begin
                r_agg_r <= r_in_r;
                for (int i = 0; i < 3; i++) begin
                    r_agg_c[i] <= r_in_c[i];
                end
            end

            if (r_state == ST_GROW) begin
                r_agg_r <= r_r[CW] ? {CW{1'b1}} : r_r[CW-1:0];
            end

            if (r_state == ST_DIVIDE && w_done) begin
                r_agg_c[r_ax] <= w_newc[CW-1:0];
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_ax   <= 2'd0;
                    r_sq   <= '0;
                    r_sat  <= 1'b0;
                    r_in_r <= w_in_r;
                    for (int i = 0; i < 3; i++) begin
                        r_in_c[i] <= w_in_c[i];
                        r_neg[i]  <= w_off[i][OW-1];
                        r_mag[i]  <= w_mag[i];
                    end
                    if (!w_sv) begin
                        r_case <= CASE_IGNORED;
                    end else if (w_copy) begin
                        r_case <= CASE_FIRST;
                    end else begin
                        r_case <= CASE_GROWN;
                    end
                end
            end
            ST_SQUARE: begin
                if (w_done) begin
                    r_sq <= r_sq + w_acc;
                    r_ax <= (r_ax == 2'd2) ? 2'd0 : r_ax + 2'd1;
                end
            end
            ST_ROOT: begin
                if (w_done) begin
                    r_d <= w_q;
                end
            end
            ST_CLASS: begin
                r_r <= w_total[OW:1];
                if (w_contained) begin
                    r_case <= CASE_CONTAINED;
                end else if (w_replace) begin
                    r_case <= CASE_REPLACED;
                end else begin
                    r_case <= CASE_GROWN;
                end
            end
            ST_GROW: begin
                // shift scale uses the unclipped radius
                r_k   <= r_r - OW'(r_agg_r);
                r_sat <= r_r[CW];
            end
            ST_DIVIDE: begin
                if (w_done) begin
                    r_ax <= r_ax + 2'd1;
                end
            end
            ST_FIN: begin
                if (w_out_free) begin
                    r_m_data <= TDW'({r_agg_r, r_agg_c[2], r_agg_c[1], r_agg_c[0]});
                    r_m_user <= {r_sat, r_case, r_agg_valid};
                end
            end
            default: begin
                r_ax <= r_ax;
            end
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

endmodule

FILE: src/bsm_checker.sv
// ----------------------------------------------------------------------------
// bsm_checker
// Port-level checks on the bounding sphere merge block, bound to the top.
// ----------------------------------------------------------------------------
module bsm_checker
    import bsm_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 s_axis_tvalid,
    input logic                                 s_axis_tready,
    input logic [((4*COORD_WIDTH+7)/8)*8-1:0]   s_axis_tdata,
    input logic [1:0]                           s_axis_tuser,
    input logic                                 m_axis_tvalid,
    input logic                                 m_axis_tready,
    input logic [((4*COORD_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    input logic [4:0]                           m_axis_tuser
);

    localparam int CW = COORD_WIDTH;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

    // one beat in flight at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken again right after an accept");

    // an invalid aggregate only comes from reset or restart, so it is all zero
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
            m_axis_tdata == '0 && m_axis_tuser[3:1] == CASE_IGNORED)
        else $error("invalid aggregate with nonzero fields");

    a_sat_grown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[4] |->
            m_axis_tuser[3:1] == CASE_GROWN && (&m_axis_tdata[3*CW +: CW]))
        else $error("saturation flagged outside a clipped grow");

    a_merge_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[3:1] != CASE_IGNORED |-> m_axis_tuser[0])
        else $error("merge result without a valid aggregate");

endmodule

bind bounding_sphere_merge bsm_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_bsm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: verif/bounding_sphere_merge_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_sphere_merge_checker
// Watches both stream channels of the sphere merge block, folds every accepted
// input beat into its own running aggregate sphere and compares each result
// beat field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module bounding_sphere_merge_checker
    import bsm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    input  logic         i_s_axis_tready,
    // in_center_x, in_center_y, in_center_z, in_radius
    input  logic [127:0] i_s_axis_tdata,
    // restart, sphere_valid
    input  logic [1:0]   i_s_axis_tuser,
    input  logic         i_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_center_x, out_center_y, out_center_z, out_radius
    input  logic [127:0] i_m_axis_tdata,
    // out_valid, merge_case[2:0], radius_saturated
    input  logic [4:0]   i_m_axis_tuser,
    output int           o_fail_count,
    output int           o_pending
);

    typedef struct packed {
        logic        valid;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] radius;
        t_case       kind;
        logic        sat;
    } t_bound;

    logic        agg_valid;
    logic [31:0] agg_center [3];
    logic [31:0] agg_radius;
    t_bound      expected_bounds [$];

    // floor of the square root, exact on the full sum of squares
    function automatic logic [63:0] int_sqrt(logic [127:0] n);
        logic [63:0]  root;
        logic [127:0] trial;
        root = '0;
        for (int b = 35; b >= 0; b--) begin
            trial = {64'd0, root | (64'd1 << b)};
            if (trial * trial <= n) begin
                root = trial[63:0];
            end
        end
        return root;
    endfunction

    function automatic t_bound merge_into_aggregate(logic [1:0] flags, logic [127:0] sphere);
        longint       offset [3];
        logic [63:0]  mag [3];
        logic [127:0] sum_sq;
        logic [127:0] shift;
        logic [63:0]  center_gap;
        logic [63:0]  r_in;
        logic [63:0]  r_agg;
        logic [63:0]  r_new;
        logic [63:0]  grow;
        longint       moved;
        t_case        kind;
        logic         clipped;
        t_bound       res;
        kind    = CASE_IGNORED;
        clipped = 1'b0;
        r_in    = {32'd0, sphere[127:96]};
        if (flags[0]) begin
            agg_valid  = 1'b0;
            agg_center = '{default: '0};
            agg_radius = '0;
        end
        if (!flags[1]) begin
            kind = CASE_IGNORED;
        end else if (!agg_valid) begin
            for (int i = 0; i < 3; i++) agg_center[i] = sphere[32*i +: 32];
            agg_radius = sphere[127:96];
            agg_valid  = 1'b1;
            kind       = CASE_FIRST;
        end else begin
            r_agg  = {32'd0, agg_radius};
            sum_sq = '0;
            for (int i = 0; i < 3; i++) begin
                offset[i] = longint'($signed(sphere[32*i +: 32]))
                          - longint'($signed(agg_center[i]));
                mag[i]    = offset[i] < 0 ? 64'(-offset[i]) : 64'(offset[i]);
                sum_sq    = sum_sq + {64'd0, mag[i]} * {64'd0, mag[i]};
            end
            center_gap = int_sqrt(sum_sq);
            // ties go to contained before replaced
            if (center_gap + r_in <= r_agg) begin
                kind = CASE_CONTAINED;
            end else if (center_gap + r_agg <= r_in) begin
                for (int i = 0; i < 3; i++) agg_center[i] = sphere[32*i +: 32];
                agg_radius = sphere[127:96];
                kind       = CASE_REPLACED;
            end else begin
                r_new = (center_gap + r_agg + r_in) >> 1;
                grow  = r_new - r_agg;
                // center shift uses the radius before clipping
                if (center_gap != 0) begin
                    for (int i = 0; i < 3; i++) begin
                        shift = ({64'd0, mag[i]} * {64'd0, grow}) / {64'd0, center_gap};
                        moved = offset[i] < 0
                              ? longint'($signed(agg_center[i])) - longint'(shift[63:0])
                              : longint'($signed(agg_center[i])) + longint'(shift[63:0]);
                        agg_center[i] = moved[31:0];
                    end
                end
                if (r_new > 64'hFFFF_FFFF) begin
                    r_new   = 64'hFFFF_FFFF;
                    clipped = 1'b1;
                end
                agg_radius = r_new[31:0];
                kind       = CASE_GROWN;
            end
        end
        res.valid  = agg_valid;
        res.cx     = agg_center[0];
        res.cy     = agg_center[1];
        res.cz     = agg_center[2];
        res.radius = agg_radius;
        res.kind   = kind;
        res.sat    = clipped;
        return res;
    endfunction

    function automatic int field_diff(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_bound want;
        t_bound pred;
        int     errs;
        errs = 0;
        if (!i_rst_n) begin
            agg_valid  = 1'b0;
            agg_center = '{default: '0};
            agg_radius = '0;
            expected_bounds.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                pred            = merge_into_aggregate(i_s_axis_tuser, i_s_axis_tdata);
                expected_bounds = {expected_bounds, pred};
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_bounds.size() == 0) begin
                    $error("result beat with no prediction pending");
                    errs++;
                end else begin
                    want = expected_bounds.pop_front();
                    errs += field_diff("out_valid", want.valid, i_m_axis_tuser[0]);
                    errs += field_diff("out_center_x", want.cx, i_m_axis_tdata[31:0]);
                    errs += field_diff("out_center_y", want.cy, i_m_axis_tdata[63:32]);
                    errs += field_diff("out_center_z", want.cz, i_m_axis_tdata[95:64]);
                    errs += field_diff("out_radius", want.radius, i_m_axis_tdata[127:96]);
                    errs += field_diff("merge_case", want.kind, i_m_axis_tuser[3:1]);
                    errs += field_diff("radius_saturated", want.sat, i_m_axis_tuser[4]);
                end
            end
        end
        o_pending    <= expected_bounds.size();
        o_fail_count <= o_fail_count + errs;
    end

endmodule

FILE: verif/bounding_sphere_merge_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounding_sphere_merge_test
// Drives sphere beats into the merge block: a directed set covering every
// merge outcome, ties, full-range corners and radius clipping, then random
// runs under changing sender and receiver idling. Checking is done by the
// checker instance beside the block; this module gives the verdict.
// ----------------------------------------------------------------------------
module bounding_sphere_merge_test;
    import bsm_pkg::*;

    localparam int          STALL_LIMIT = 5000;
    localparam int          HOLD_CYCLES = 600;
    localparam int          TAIL_CYCLES = 250;
    localparam logic [31:0] C_MAX       = 32'h7FFF_FFFF;
    localparam logic [31:0] C_MIN       = 32'h8000_0000;
    localparam logic [31:0] R_MAX       = 32'hFFFF_FFFF;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata  = '0;
    logic [1:0]   s_axis_tuser  = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic [4:0]   m_axis_tuser;

    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;
    int   hold_cnt    = 0;
    int   fail_count;
    int   pending_results;

    bounding_sphere_merge #(
        .COORD_WIDTH(32)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bounding_sphere_merge_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending_results)
    );

    always #5 i_clk = ~i_clk;

    // result side: random stalls, plus one long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_req && !hold_done) begin
            m_axis_tready <= 1'b0;
            hold_cnt      <= hold_cnt + 1;
            if (hold_cnt == HOLD_CYCLES - 1) begin
                hold_done <= 1'b1;
            end
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_sphere(logic restart, logic sphere_valid, logic [31:0] cx,
                               logic [31:0] cy, logic [31:0] cz, logic [31:0] radius);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= {sphere_valid, restart};
        s_axis_tdata  <= {radius, cz, cy, cx};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
    endtask

    // mostly a small neighborhood so all merge outcomes occur, some full range
    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 19))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 3))
                    0:       return C_MAX;
                    1:       return C_MIN;
                    2:       return '0;
                    default: return '1;
                endcase
            end
            default: return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_radius();
        case ($urandom_range(0, 19))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 2))
                    0:       return '0;
                    1:       return 32'd1;
                    default: return R_MAX;
                endcase
            end
            default: return $urandom_range(0, 32'h0018_0000);
        endcase
    endfunction

    task automatic random_spheres(int count);
        repeat (count) begin
            send_sphere($urandom_range(0, 99) < 8, $urandom_range(0, 99) < 90,
                        pick_coord(), pick_coord(), pick_coord(), pick_radius());
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // invalid beat on an empty aggregate
        send_sphere(1'b0, 1'b0, C_MAX, C_MIN, '1, R_MAX);
        send_sphere(1'b0, 1'b1, C_MAX, C_MIN, '0, '0);
        // identical point sphere: tie counts as contained
        send_sphere(1'b0, 1'b1, C_MAX, C_MIN, '0, '0);
        send_sphere(1'b0, 1'b1, C_MAX, C_MIN, '0, 32'd5);
        send_sphere(1'b0, 1'b0, '0, '0, '0, '0);
        send_sphere(1'b1, 1'b1, '0, '0, '0, 32'd10);
        // exact distance 5: contained on equality, then replaced on equality
        send_sphere(1'b0, 1'b1, 32'd3, 32'd4, '0, 32'd5);
        send_sphere(1'b0, 1'b1, 32'd3, 32'd4, '0, 32'd15);
        send_sphere(1'b0, 1'b1, 32'd100, 32'hFFFF_FFCE, 32'd7, 32'd1);
        // restart with an invalid sphere leaves a cleared aggregate
        send_sphere(1'b1, 1'b0, C_MAX, C_MAX, C_MAX, R_MAX);
        send_sphere(1'b0, 1'b1, C_MIN, C_MIN, C_MIN, '0);
        send_sphere(1'b0, 1'b1, C_MAX, C_MAX, C_MAX, '0);
        // radius clipping
        send_sphere(1'b1, 1'b1, '0, '0, '0, R_MAX);
        send_sphere(1'b0, 1'b1, C_MAX, '0, '0, R_MAX);
        send_sphere(1'b0, 1'b1, C_MIN, C_MIN, C_MIN, R_MAX);
        send_sphere(1'b1, 1'b1, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_8000, 32'h0002_0000);
        send_sphere(1'b0, 1'b1, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'd1);
        send_sphere(1'b0, 1'b1, 32'h0003_0000, 32'h0003_0000, 32'hFFFD_0000, 32'h0001_0000);
        wait_drained();

        tx_idle_pct = 27;
        rx_idle_pct = 69;
        random_spheres(280);
        wait_drained();

        tx_idle_pct = 69;
        rx_idle_pct = 27;
        random_spheres(280);
        wait_drained();

        // no idling; the long hold-off makes the block back up its input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req    <= 1'b1;
        random_spheres(290);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
src/bsm_pkg.sv
src/bsm_iter.sv
src/bounding_sphere_merge.sv
src/bsm_checker.sv
verif/bounding_sphere_merge_checker.sv
verif/bounding_sphere_merge_test.sv
